/* sv/mut_pkg.sv */
// Shared types, constants and the fractional log2 table for the Maurer test core.
package mut_pkg;

    localparam int ACC_W    = 48;
    localparam int VAL_W    = 17;
    localparam int OUT_CNT_W = 32;
    localparam int REG_W    = 16;
    localparam int TBL_W    = 9;
    localparam int NUM_MUL  = 22272;
    localparam int DEN_MUL  = 625;
    localparam int NUM_W    = 63;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_ONE = 17'h10000;

    localparam logic REG_WARMUP = 1'b0;
    localparam logic REG_TEST   = 1'b1;

    typedef logic [TBL_W-1:0] log_tbl_t [256];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_NORM,
        ST_UPDATE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] sym;
    } queue_item_t;

    function automatic logic [TBL_W-1:0] frac_log(input int m);
        logic [63:0] x;
        logic [63:0] r;
        x = 64'(256 + m) << 22;
        r = '0;
        for (int i = 0; i < 20; i++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r = r | 64'd1;
            end
        end
        r = (r + (64'd1 << 11)) >> 12;
        return r[TBL_W-1:0];
    endfunction

    function automatic log_tbl_t build_log_tbl();
        log_tbl_t t;
        for (int m = 0; m < 256; m++) begin
            t[m] = frac_log(m);
        end
        return t;
    endfunction

    localparam log_tbl_t LOG_TBL = build_log_tbl();

endpackage

/* sv/maurer_universal_test_core.sv */
// Top level of the Maurer universal test core: input queue, processing engine, config registers.
// Each byte is processed in turn: the normalize loop and the 18-step divider take the
// bulk of the work, and warmup bytes skip both.
// The back end takes a new byte only after the previous result is loaded for output,
// which waits on m_ready; the input queue holds two more bytes meanwhile.
// Reset (aresetn low, synchronous): state and last-seen valid bits clear, registers 2000/2000.
module maurer_universal_test_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mut_pkg::REG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_sample_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ready_res,
    output logic [mut_pkg::VAL_W-1:0]     m_test_value,
    output logic [mut_pkg::ACC_W-1:0]     m_log_sum,
    output logic [mut_pkg::OUT_CNT_W-1:0] m_byte_count,
    output logic                          m_count_saturated
);
    import mut_pkg::*;

    logic [REG_W-1:0] warmup_reg;
    logic [REG_W-1:0] test_reg;
    queue_item_t      q_head;
    logic             q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg <= 16'd2000;
            test_reg   <= 16'd2000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WARMUP: warmup_reg <= cfg_wdata;
                REG_TEST:   test_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mut_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_byte (s_sample_byte),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    mut_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .warmup_bytes      (warmup_reg),
        .test_bytes        (test_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ready_res       (m_ready_res),
        .m_test_value      (m_test_value),
        .m_log_sum         (m_log_sum),
        .m_byte_count      (m_byte_count),
        .m_count_saturated (m_count_saturated)
    );

`ifndef SYNTHESIS
    a_val_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_test_value <= VAL_ONE))
        else $error("test value above one");
    a_val_needs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_test_value != '0) |-> m_ready_res)
        else $error("test value without ready");
    a_sat_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_count_saturated) |=> !(m_valid && !m_count_saturated))
        else $error("saturation flag cleared");
`endif
endmodule

/* sv/mut_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* sv/mut_front.sv */
// Input side: takes byte transfers into a two-entry queue for the back end.
module mut_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_sample_byte,
    output mut_pkg::queue_item_t q_head,
    input  logic             q_pop
);
    import mut_pkg::*;

    logic [7:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       pop;

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (fill_reg != 2'd0);

    assign q_head.valid = (fill_reg != 2'd0);
    assign q_head.sym   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_sample_byte;
        end
    end
endmodule

/* sv/mut_back.sv */
// Processing side: distance lookup, iterative log2, accumulation and iterative divide.
module mut_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mut_pkg::queue_item_t              q_head,
    output logic                              q_pop,
    input  logic [mut_pkg::REG_W-1:0]         warmup_bytes,
    input  logic [mut_pkg::REG_W-1:0]         test_bytes,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ready_res,
    output logic [mut_pkg::VAL_W-1:0]         m_test_value,
    output logic [mut_pkg::ACC_W-1:0]         m_log_sum,
    output logic [mut_pkg::OUT_CNT_W-1:0]     m_byte_count,
    output logic                              m_count_saturated
);
    import mut_pkg::*;

    localparam int PW   = $clog2(COUNT_BITS);
    localparam int NH   = COUNT_BITS / 2;
    localparam int DW   = COUNT_BITS + 10;
    localparam int DSW  = DW + VAL_W;
    localparam int CW   = (DSW > NUM_W) ? DSW : NUM_W;
    localparam int LW   = PW + 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    back_state_t state_reg, state_next;

    logic [7:0]            sym_reg;
    logic                  vld_reg;
    logic [255:0]          seen_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic                  sat_reg;
    logic                  add_reg;
    logic [COUNT_BITS-1:0] sh_reg;
    logic [PW-1:0]         p_reg;
    logic                  rdy_reg;
    logic                  ven_reg;
    logic [38:0]           nlo_reg, nhi_reg;
    logic [NH+9:0]         dlo_reg;
    logic [COUNT_BITS-NH+9:0] dhi_reg;
    logic [CW-1:0]         rem_reg;
    logic [CW-1:0]         dsh_reg;
    logic [VAL_W-1:0]      q_reg;
    logic                  over_reg;
    logic [4:0]            step_reg;

    logic                  m_valid_reg;
    logic                  res_rdy_reg;
    logic [VAL_W-1:0]      res_val_reg;
    logic [ACC_W-1:0]      res_sum_reg;
    logic [OUT_CNT_W-1:0]  res_cnt_reg;
    logic                  res_sat_reg;

    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [COUNT_BITS-1:0] last_val;
    logic [COUNT_BITS-1:0] dist_val;
    logic [LW-1:0]         log_val;
    logic [ACC_W:0]        acc_sum;
    logic [COUNT_BITS:0]   rdy_lim;
    logic [COUNT_BITS-1:0] warm_ext;
    logic [COUNT_BITS-1:0] n_val;
    logic [NUM_W-1:0]      num_val;
    logic [DW-1:0]         den_val;
    logic                  ge;
    logic                  load_out;
    logic [VAL_W-1:0]      final_val;

    mut_ram #(.WIDTH(COUNT_BITS), .DEPTH(256)) u_last (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sym_reg),
        .wdata (cnt_reg),
        .re    (q_pop),
        .raddr (q_head.sym),
        .rdata (ram_rdata)
    );

    assign warm_ext = COUNT_BITS'(warmup_bytes);
    assign last_val = vld_reg ? ram_rdata : '0;
    assign dist_val = (cnt_reg == last_val) ? COUNT_BITS'(1) : cnt_reg - last_val;
    assign log_val  = {p_reg, 8'b0} + LW'(LOG_TBL[sh_reg[COUNT_BITS-2 -: 8]]);
    assign acc_sum  = {1'b0, acc_reg} + (ACC_W+1)'(log_val);
    assign rdy_lim  = (COUNT_BITS+1)'(warmup_bytes) + (COUNT_BITS+1)'(test_bytes);
    assign n_val    = cnt_reg - warm_ext;
    assign num_val  = (NUM_W'(nhi_reg) << 24) + NUM_W'(nlo_reg);
    assign den_val  = (DW'(dhi_reg) << NH) + DW'(dlo_reg);
    assign ge       = (rem_reg >= dsh_reg);
    assign ram_we   = (state_reg == ST_UPDATE);
    assign q_pop    = (state_reg == ST_IDLE) && q_head.valid;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign final_val = (over_reg || q_reg > VAL_ONE) ? VAL_ONE : q_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) state_next = ST_READ;
            end
            ST_READ: begin
                if (cnt_reg == CNT_MAX) begin
                    state_next = ST_MUL;
                end else if (cnt_reg >= warm_ext) begin
                    state_next = ST_NORM;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_NORM: begin
                if (sh_reg[COUNT_BITS-1]) state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_MUL;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ven_reg ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (step_reg == 5'd0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seen_reg    <= '0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_READ && cnt_reg == CNT_MAX) begin
                sat_reg <= 1'b1;
            end
            if (state_reg == ST_UPDATE) begin
                seen_reg[sym_reg] <= 1'b1;
                cnt_reg <= cnt_reg + COUNT_BITS'(1);
                if (add_reg) begin
                    acc_reg <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sym_reg <= q_head.sym;
                vld_reg <= seen_reg[q_head.sym];
            end
            ST_READ: begin
                add_reg <= (cnt_reg >= warm_ext);
                sh_reg  <= dist_val;
                p_reg   <= PW'(COUNT_BITS - 1);
            end
            ST_NORM: begin
                if (!sh_reg[COUNT_BITS-1]) begin
                    sh_reg <= sh_reg << 1;
                    p_reg  <= p_reg - PW'(1);
                end
            end
            ST_MUL: begin
                rdy_reg <= ((COUNT_BITS+1)'(cnt_reg) >= rdy_lim);
                ven_reg <= ((COUNT_BITS+1)'(cnt_reg) >= rdy_lim) && (cnt_reg > warm_ext);
                nlo_reg <= 39'(acc_reg[23:0]) * 39'(NUM_MUL);
                nhi_reg <= 39'(acc_reg[47:24]) * 39'(NUM_MUL);
                dlo_reg <= (NH+10)'(n_val[NH-1:0]) * (NH+10)'(DEN_MUL);
                dhi_reg <= (COUNT_BITS-NH+10)'(n_val[COUNT_BITS-1:NH])
                           * (COUNT_BITS-NH+10)'(DEN_MUL);
            end
            ST_SUM: begin
                rem_reg  <= CW'(num_val);
                dsh_reg  <= CW'(den_val) << (VAL_W);
                q_reg    <= '0;
                over_reg <= 1'b0;
                step_reg <= 5'(VAL_W);
            end
            ST_DIV: begin
                if (step_reg == 5'(VAL_W)) begin
                    over_reg <= ge;
                end else begin
                    q_reg <= {q_reg[VAL_W-2:0], ge};
                    if (ge) rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 5'd1;
            end
            default: ;
        endcase
        if (load_out) begin
            res_rdy_reg <= rdy_reg;
            res_val_reg <= ven_reg ? final_val : '0;
            res_sum_reg <= acc_reg;
            res_cnt_reg <= OUT_CNT_W'(cnt_reg);
            res_sat_reg <= sat_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ready_res       = res_rdy_reg;
    assign m_test_value      = res_val_reg;
    assign m_log_sum         = res_sum_reg;
    assign m_byte_count      = res_cnt_reg;
    assign m_count_saturated = res_sat_reg;
endmodule
